// ----- hw/rtl/ket_pkg.sv -----
// keyed expiry timer table: shared types and command codes
// no dependencies
package ket_pkg;

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_MODIFY = 3'd1;
	localparam logic [2:0] CMD_REMOVE = 3'd2;
	localparam logic [2:0] CMD_QUERY  = 3'd3;
	localparam logic [2:0] CMD_TICK   = 3'd4;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] id;
		logic [31:0] expiry;
	} entry_t;

endpackage

// ----- hw/rtl/ket_ram.sv -----
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module ket_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 32,
	parameter int AW = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/keyed_expiry_timer_table.sv -----
// keyed expiry timer table top level: control sequencer around the entry ram
// depends on ket_pkg and ket_ram
//
// channel | direction | fields
// in      | input     | cmd, entry_key, entry_id, time_value, now
// out     | output    | kind, found, table_full, out_key, out_id, last
//
// lookups scan the ram entry by entry, a read state then a compare state, until the first match
// remove and tick compact the table in one pass, reading each entry in S_MRD and judging it in S_MEV
// a new item is taken only in S_IDLE, after the last one is done; each result waits for out_ready
// reset empties the table at once through the entry count, no clearing pass
module keyed_expiry_timer_table
	import ket_pkg::*;
#(
	parameter int TABLE_DEPTH = 32,
	parameter int MAX_RESULTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [31:0] entry_key,
	input  logic [31:0] entry_id,
	input  logic [31:0] time_value,
	input  logic [31:0] now,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic        found,
	output logic        table_full,
	output logic [31:0] out_key,
	output logic [31:0] out_id,
	output logic        last
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int NW = $clog2(MAX_RESULTS + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FRD   = 3'd1;
	localparam logic [2:0] S_FEV   = 3'd2;
	localparam logic [2:0] S_ACT   = 3'd3;
	localparam logic [2:0] S_MRD   = 3'd4;
	localparam logic [2:0] S_MEV   = 3'd5;
	localparam logic [2:0] S_REPLY = 3'd6;
	localparam logic [2:0] S_FLUSH = 3'd7;

	logic [2:0]    state_q;
	logic [2:0]    cmd_q;
	logic [31:0]   key_q, id_q, tval_q, now_q;
	logic [CW-1:0] i_q, w_q, cnt_q, pos_q;
	logic [NW-1:0] n_q;
	logic          hit_q, full_q, pend_q;
	logic [31:0]   pkey_q, pid_q;
	logic          we_q;
	logic [AW-1:0] wa_q;
	entry_t        wd_q;
	entry_t        rd;
	logic          out_free, expired;
	logic          wr_en, emit;
	logic          out_valid_q, kind_q, found_q, tfull_q, last_q;
	logic [31:0]   okey_q, oid_q;

	ket_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_DEPTH),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(we_q),
		.waddr(wa_q),
		.wdata(wd_q),
		.raddr(i_q[AW-1:0]),
		.rdata(rd)
	);

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign expired = (cmd_q == CMD_TICK) && (n_q < NW'(MAX_RESULTS)) &&
		(rd.expiry != 32'd0) && (rd.expiry <= now_q) &&
		(rd.key != 32'd0) && (rd.id != 32'd0);

	// ram write strobe and result load for the next cycle
	assign wr_en = ((state_q == S_ACT) &&
		(((cmd_q == CMD_INSERT) && (hit_q || (cnt_q < CW'(TABLE_DEPTH)))) ||
		((cmd_q == CMD_MODIFY) && hit_q))) ||
		((state_q == S_MEV) && !expired);
	assign emit = out_free && ((state_q == S_REPLY) || (state_q == S_FLUSH) ||
		((state_q == S_MEV) && expired && pend_q));

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign found      = found_q;
	assign table_full = tfull_q;
	assign out_key    = okey_q;
	assign out_id     = oid_q;
	assign last       = last_q;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q  <= cmd;
			key_q  <= entry_key;
			id_q   <= entry_id;
			tval_q <= time_value;
			now_q  <= now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			we_q        <= wr_en;
			out_valid_q <= emit || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			i_q         <= '0;
			w_q         <= '0;
			cnt_q       <= '0;
			pos_q       <= '0;
			n_q         <= '0;
			hit_q       <= 1'b0;
			full_q      <= 1'b0;
			pend_q      <= 1'b0;
			pkey_q      <= '0;
			pid_q       <= '0;
			wa_q        <= '0;
			wd_q        <= '0;
			kind_q      <= 1'b0;
			found_q     <= 1'b0;
			tfull_q     <= 1'b0;
			last_q      <= 1'b0;
			okey_q      <= '0;
			oid_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						i_q    <= '0;
						w_q    <= '0;
						n_q    <= '0;
						hit_q  <= 1'b0;
						full_q <= 1'b0;
						pend_q <= 1'b0;
						if (cmd == CMD_TICK) begin
							state_q <= S_MRD;
						end else if (cmd > CMD_TICK) begin
							state_q <= S_REPLY;
						end else if (cnt_q == '0) begin
							state_q <= S_ACT;
						end else begin
							state_q <= S_FRD;
						end
					end
				end
				S_FRD: begin
					state_q <= S_FEV;
				end
				S_FEV: begin
					if (rd.key == key_q && rd.id == id_q) begin
						hit_q   <= 1'b1;
						pos_q   <= i_q;
						state_q <= S_ACT;
					end else if ((i_q + 1'b1) == cnt_q) begin
						state_q <= S_ACT;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_FRD;
					end
				end
				S_ACT: begin
					state_q <= S_REPLY;
					case (cmd_q)
						CMD_INSERT: begin
							if (hit_q) begin
								wa_q <= pos_q[AW-1:0];
								wd_q <= '{key: key_q, id: id_q, expiry: tval_q + now_q};
							end else if (cnt_q < CW'(TABLE_DEPTH)) begin
								wa_q  <= cnt_q[AW-1:0];
								wd_q  <= '{key: key_q, id: id_q, expiry: tval_q + now_q};
								cnt_q <= cnt_q + 1'b1;
							end else begin
								full_q <= 1'b1;
							end
						end
						CMD_MODIFY: begin
							if (hit_q) begin
								wa_q <= pos_q[AW-1:0];
								wd_q <= '{key: key_q, id: id_q, expiry: tval_q};
							end
						end
						CMD_REMOVE: begin
							if (hit_q) begin
								i_q     <= pos_q + 1'b1;
								w_q     <= pos_q;
								state_q <= S_MRD;
							end
						end
						default: begin
						end
					endcase
				end
				S_MRD: begin
					if (i_q == cnt_q) begin
						cnt_q   <= w_q;
						state_q <= pend_q ? S_FLUSH : S_REPLY;
					end else begin
						state_q <= S_MEV;
					end
				end
				S_MEV: begin
					if (expired) begin
						if (!pend_q || out_free) begin
							if (pend_q) begin
								kind_q      <= 1'b1;
								found_q     <= 1'b0;
								tfull_q     <= 1'b0;
								last_q      <= 1'b0;
								okey_q      <= pkey_q;
								oid_q       <= pid_q;
							end
							pend_q  <= 1'b1;
							pkey_q  <= rd.key;
							pid_q   <= rd.id;
							n_q     <= n_q + 1'b1;
							i_q     <= i_q + 1'b1;
							state_q <= S_MRD;
						end
					end else begin
						wa_q    <= w_q[AW-1:0];
						wd_q    <= rd;
						w_q     <= w_q + 1'b1;
						i_q     <= i_q + 1'b1;
						state_q <= S_MRD;
					end
				end
				S_REPLY: begin
					if (out_free) begin
						kind_q      <= 1'b0;
						found_q     <= hit_q;
						tfull_q     <= full_q;
						last_q      <= 1'b1;
						okey_q      <= key_q;
						oid_q       <= id_q;
						state_q     <= S_IDLE;
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						kind_q      <= 1'b1;
						found_q     <= 1'b0;
						tfull_q     <= 1'b0;
						last_q      <= 1'b1;
						okey_q      <= pkey_q;
						oid_q       <= pid_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
